/* rtl/cbm_pkg.sv */
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper with IRQ counter.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int unsigned PrgSizeW = 20;
  localparam int unsigned ChrSizeW = 19;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned CfgIdxW  = 2;

  // item kinds
  localparam logic [1:0] MODE_TICK      = 2'd0;
  localparam logic [1:0] MODE_WRITE     = 2'd1;
  localparam logic [1:0] MODE_PRG_XLATE = 2'd2;
  localparam logic [1:0] MODE_CHR_XLATE = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PRG_ROM_BYTES = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHR_ROM_BYTES = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SWAP_LINES    = 2'd2;

  localparam logic [PrgSizeW-1:0] PRG_SIZE_RESET = 20'h40000;
  localparam logic [ChrSizeW-1:0] CHR_SIZE_RESET = 19'h20000;

  // register pages (address bits 15:12)
  localparam logic [3:0] PAGE_PRG0 = 4'h8;
  localparam logic [3:0] PAGE_MIR  = 4'hB;
  localparam logic [3:0] PAGE_PRG1 = 4'hC;
  localparam logic [3:0] PAGE_CHR0 = 4'hD;
  localparam logic [3:0] PAGE_CHR1 = 4'hE;
  localparam logic [3:0] PAGE_IRQ  = 4'hF;

  // sub-registers (address bits 1:0)
  localparam logic [1:0] SUB_MIRROR     = 2'd3;
  localparam logic [1:0] SUB_IRQ_RELOAD = 2'd0;
  localparam logic [1:0] SUB_IRQ_CTRL   = 2'd1;
  localparam logic [1:0] SUB_IRQ_ACK    = 2'd2;

  // scanline prescaler
  localparam logic signed [9:0] PRESCALE_RELOAD = 10'sd341;
  localparam logic signed [9:0] PRESCALE_STEP   = 10'sd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } in_word_t;

  typedef struct packed {
    logic [18:0] rom_address;
    logic        irq_line;
    logic [1:0]  mirror_mode;
    logic        ram_enabled;
  } out_word_t;

  typedef struct packed {
    logic tick;
    logic load_reload;
    logic load_ctrl;
    logic ack;
  } irq_ctl_t;

endpackage

/* rtl/cbm_irq.sv */
// ----------------------------------------------------------------------------
// cbm_irq
// Interrupt counter: cycle or scanline mode, reload value, control and ack.
// ----------------------------------------------------------------------------
module cbm_irq (
  input  logic              clk,
  input  logic              rst,
  input  cbm_pkg::irq_ctl_t ctl,
  input  logic [7:0]        data,
  output logic              pending_next
);
  import cbm_pkg::*;

  logic [7:0]        count, count_next;
  logic [7:0]        reload, reload_next;
  logic              enabled, enabled_next;
  logic              rearm, rearm_next;
  logic              scanline, scanline_next;
  logic              pending;
  logic signed [9:0] prescaler, prescaler_next;
  logic signed [9:0] pre_dec;
  logic              advance;

  always_comb begin
    count_next     = count;
    reload_next    = reload;
    enabled_next   = enabled;
    rearm_next     = rearm;
    scanline_next  = scanline;
    pending_next   = pending;
    prescaler_next = prescaler;
    pre_dec        = prescaler - PRESCALE_STEP;
    advance        = 1'b1;

    if (ctl.tick && enabled) begin
      if (scanline) begin
        advance        = (pre_dec <= 10'sd0);
        prescaler_next = advance ? pre_dec + PRESCALE_RELOAD : pre_dec;
      end
      if (advance) begin
        if (count == 8'hFF) begin
          count_next   = reload;
          pending_next = 1'b1;
        end else begin
          count_next = count + 8'd1;
        end
      end
    end

    if (ctl.load_reload) begin
      reload_next = data;
    end

    if (ctl.load_ctrl) begin
      pending_next  = 1'b0;
      rearm_next    = data[0];
      enabled_next  = data[1];
      scanline_next = ~data[2];
      if (data[1]) begin
        count_next     = reload;
        prescaler_next = PRESCALE_RELOAD;
      end
    end

    if (ctl.ack) begin
      pending_next = 1'b0;
      enabled_next = rearm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      reload    <= '0;
      enabled   <= 1'b0;
      rearm     <= 1'b0;
      scanline  <= 1'b0;
      pending   <= 1'b0;
      prescaler <= PRESCALE_RELOAD;
    end else begin
      count     <= count_next;
      reload    <= reload_next;
      enabled   <= enabled_next;
      rearm     <= rearm_next;
      scanline  <= scanline_next;
      pending   <= pending_next;
      prescaler <= prescaler_next;
    end
  end

endmodule

/* rtl/cartridge_bank_mapper_with_irq_core.sv */
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq_core
// Bank-switch mapper: register writes, PRG/CHR address translation and a
// scanline/cycle interrupt counter, one word per clock while in_ready is high.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | in_word (mode, address, data)
//  out     | output    | out_valid/out_ready| out_word (rom addr, irq, mirror, ram)
//  cfg     | input     | cfg_write          | cfg_index, cfg_data
//
//  one word accepted per cycle while in_ready is high; its result goes to out_word, or to the skid while out stalls
//  all work is one combinational pass from the accepted word and state
//  a two-entry output buffer (register plus skid) lets one more word in while
//  out is stalled; in_ready drops only while the skid holds
//  synchronous reset; no clearing pass
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_irq_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cbm_pkg::in_word_t               in_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cbm_pkg::out_word_t              out_word,
  input  logic                            cfg_write,
  input  logic [cbm_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [cbm_pkg::CfgDataW-1:0]    cfg_data
);
  import cbm_pkg::*;

  logic [PrgSizeW-1:0] prg_rom_len;
  logic [ChrSizeW-1:0] chr_rom_len;
  logic                swap_lines;

  logic [4:0] program_banks [2];
  logic [7:0] character_banks [8];
  logic [1:0] mirror_select;
  logic       ram_enable_flag;

  logic        in_fire, out_fire, wr;
  logic [15:0] addr;
  logic [3:0]  page;
  logic        prg_we, chr_we, mir_we;
  logic [2:0]  chr_idx;
  irq_ctl_t    irq_ctl;
  logic        irq_pending_next;

  logic [PrgSizeW-1:0] prg_off, prg_full;
  logic [15:0]         prg_low;
  logic [ChrSizeW-1:0] chr_full;
  logic [7:0]          chr_page_bank;

  out_word_t result;
  out_word_t skid_word;
  logic      skid_valid;

  assign in_ready = ~skid_valid;
  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;

  // register write decode
  always_comb begin
    addr = swap_lines ? {in_word.bus_address[15:2], in_word.bus_address[0],
                         in_word.bus_address[1]} : in_word.bus_address;
    page    = addr[15:12];
    wr      = in_fire && (in_word.mode == MODE_WRITE);
    prg_we  = wr && (page == PAGE_PRG0 || page == PAGE_PRG1);
    chr_we  = wr && (page == PAGE_CHR0 || page == PAGE_CHR1);
    mir_we  = wr && (page == PAGE_MIR) && (addr[1:0] == SUB_MIRROR);
    chr_idx = {~addr[12], addr[1:0]};
    irq_ctl.tick        = in_fire && (in_word.mode == MODE_TICK);
    irq_ctl.load_reload = wr && (page == PAGE_IRQ) && (addr[1:0] == SUB_IRQ_RELOAD);
    irq_ctl.load_ctrl   = wr && (page == PAGE_IRQ) && (addr[1:0] == SUB_IRQ_CTRL);
    irq_ctl.ack         = wr && (page == PAGE_IRQ) && (addr[1:0] == SUB_IRQ_ACK);
  end

  cbm_irq u_irq (
    .clk          (clk),
    .rst          (rst),
    .ctl          (irq_ctl),
    .data         (in_word.write_data),
    .pending_next (irq_pending_next)
  );

  // address translation
  always_comb begin
    unique case (in_word.bus_address[15:13])
      3'b100, 3'b101: prg_off = {1'b0, program_banks[0], 14'b0};
      3'b110:         prg_off = {2'b0, program_banks[1], 13'b0};
      3'b111:         prg_off = prg_rom_len - 20'h02000;
      default:        prg_off = '0;
    endcase
    prg_low  = in_word.bus_address[14] ? {3'b0, in_word.bus_address[12:0]}
                                       : {2'b0, in_word.bus_address[13:0]};
    prg_full = ({4'b0, prg_low} | prg_off) & (prg_rom_len - 20'd1);
    chr_page_bank = character_banks[in_word.bus_address[12:10]];
    chr_full = ({9'b0, in_word.bus_address[9:0]} | {1'b0, chr_page_bank, 10'b0})
               & (chr_rom_len - 19'd1);
  end

  always_comb begin
    unique case (in_word.mode)
      MODE_PRG_XLATE: result.rom_address = prg_full[18:0];
      MODE_CHR_XLATE: result.rom_address = chr_full;
      default:        result.rom_address = '0;
    endcase
    result.irq_line    = irq_pending_next;
    result.mirror_mode = mir_we ? in_word.write_data[3:2] : mirror_select;
    result.ram_enabled = mir_we ? in_word.write_data[7] : ram_enable_flag;
  end

  // configuration and bank registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_rom_len        <= PRG_SIZE_RESET;
      chr_rom_len        <= CHR_SIZE_RESET;
      swap_lines         <= 1'b0;
      program_banks[0]   <= '0;
      program_banks[1]   <= '0;
      for (int i = 0; i < 8; i++) begin
        character_banks[i] <= '0;
      end
      mirror_select      <= '0;
      ram_enable_flag    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_PRG_ROM_BYTES: prg_rom_len <= cfg_data[PrgSizeW-1:0];
          CFG_CHR_ROM_BYTES: chr_rom_len <= cfg_data[ChrSizeW-1:0];
          CFG_SWAP_LINES:    swap_lines  <= cfg_data[0];
          default: ;
        endcase
      end
      if (prg_we) begin
        program_banks[addr[14]] <= in_word.write_data[4:0];
      end
      if (chr_we) begin
        character_banks[chr_idx] <= in_word.write_data;
      end
      if (mir_we) begin
        mirror_select   <= in_word.write_data[3:2];
        ram_enable_flag <= in_word.write_data[7];
      end
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_word <= skid_word;
      end
    end else if (in_fire) begin
      if (out_valid && !out_ready) begin
        skid_word <= result;
      end else begin
        out_word <= result;
      end
    end
  end

endmodule

/* rtl/cbm_checker.sv */
// ----------------------------------------------------------------------------
// cbm_checker
// Port-level checks of the mapper's word flow, bound to the top level.
// ----------------------------------------------------------------------------
module cbm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input cbm_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_ready,
  input cbm_pkg::out_word_t out_word
);
  import cbm_pkg::*;

  // reset empties the output side
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // input back-pressure only while a result is held
  a_ready_low_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("in_ready low with no result shown");

  // an accepted word into an empty output shows next cycle
  a_accept_shows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid) |=> out_valid)
    else $error("accepted word not shown");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("stalled result changed");

  // offered input word holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=> (in_valid && $stable(in_word)))
    else $error("waiting input word changed");

endmodule

bind cartridge_bank_mapper_with_irq_core cbm_checker u_cbm_checker (.*);

/* dv/tb_cartridge_bank_mapper_with_irq_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cartridge_bank_mapper_with_irq_core
// Drives mapper words (ticks, register writes, PRG and CHR translations)
// through the valid/ready input. A local predictor computes each result word,
// and every word on the output is compared field by field. A directed table
// comes first, then random traffic with IRQ counter runs. The run goes
// through several ROM size and address swap settings and three idling
// patterns, with one long output stall.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper_with_irq_core;
  import cbm_pkg::*;

  localparam logic [15:0] REG_BASE_MASK = 16'hF000;
  localparam logic [15:0] REG_PRG_LO    = {PAGE_PRG0, 12'h000};
  localparam logic [15:0] REG_PRG_HI    = {PAGE_PRG1, 12'h000};
  localparam logic [15:0] REG_CHR_LO    = {PAGE_CHR0, 12'h000};
  localparam logic [15:0] REG_CHR_HI    = {PAGE_CHR1, 12'h000};
  localparam logic [15:0] REG_MIRROR    = {PAGE_MIR, 12'h000};
  localparam logic [15:0] REG_IRQ       = {PAGE_IRQ, 12'h000};

  localparam logic [2:0] WIN_BANK0_A = 3'b100;
  localparam logic [2:0] WIN_BANK0_B = 3'b101;
  localparam logic [2:0] WIN_BANK1   = 3'b110;
  localparam logic [2:0] WIN_FIXED   = 3'b111;

  localparam out_word_t NO_RES = '0;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } dir_row_t;

  typedef struct packed {
    logic [19:0] prg;
    logic [18:0] chr;
    logic        swap;
  } cfg_set_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_word;
  logic                 cfg_write = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  // mapper state as predicted
  logic [19:0]       m_prg_len;
  logic [18:0]       m_chr_len;
  logic              m_swap;
  logic [4:0]        m_prg_bank [2];
  logic [7:0]        m_char_banks [8];
  logic [1:0]        m_mirror;
  logic              m_ram_en;
  logic [7:0]        m_irq_cnt;
  logic [7:0]        m_irq_reload;
  logic              m_irq_en;
  logic              m_irq_rearm;
  logic              m_scan;
  logic              m_irq_pend;
  logic signed [9:0] m_presc;

  out_word_t expected_words [$];
  dir_row_t  dir_rows [$];
  cfg_set_t  cfg_sets [6];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int err_count = 0;
  int items_sent = 0;
  int irq_words = 0;
  int mode_count [4];

  cartridge_bank_mapper_with_irq_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic mapper_step(input in_word_t w, output out_word_t r);
    logic [15:0] a;
    logic [16:0] a_sum;
    logic [2:0]  ci;
    logic [19:0] off;
    logic [19:0] msk;
    logic [19:0] prg_full;
    logic [18:0] chr_full;
    logic        adv;
    r = '0;
    a = w.bus_address;
    case (w.mode)
      MODE_TICK: begin
        if (m_irq_en) begin
          adv = 1'b1;
          if (m_scan) begin
            m_presc = m_presc - PRESCALE_STEP;
            adv = (m_presc <= 0);
            if (adv) m_presc = m_presc + PRESCALE_RELOAD;
          end
          if (adv) begin
            if (m_irq_cnt == 8'hFF) begin
              m_irq_cnt = m_irq_reload;
              m_irq_pend = 1'b1;
            end else begin
              m_irq_cnt = m_irq_cnt + 8'd1;
            end
          end
        end
      end
      MODE_WRITE: begin
        if (m_swap) a = {a[15:2], a[0], a[1]};
        a_sum = {1'b0, a} + 17'h01000;
        ci = {a_sum[12], a[1:0]};
        case (a & REG_BASE_MASK)
          REG_PRG_LO, REG_PRG_HI: m_prg_bank[a[14]] = w.write_data[4:0];
          REG_CHR_LO, REG_CHR_HI: m_char_banks[ci] = w.write_data;
          REG_MIRROR: begin
            if (a[1:0] == SUB_MIRROR) begin
              m_mirror = w.write_data[3:2];
              m_ram_en = w.write_data[7];
            end
          end
          REG_IRQ: begin
            case (a[1:0])
              SUB_IRQ_RELOAD: m_irq_reload = w.write_data;
              SUB_IRQ_CTRL: begin
                m_irq_pend = 1'b0;
                m_irq_rearm = w.write_data[0];
                m_irq_en = w.write_data[1];
                m_scan = ~w.write_data[2];
                if (m_irq_en) begin
                  m_irq_cnt = m_irq_reload;
                  m_presc = PRESCALE_RELOAD;
                end
              end
              SUB_IRQ_ACK: begin
                m_irq_pend = 1'b0;
                m_irq_en = m_irq_rearm;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      MODE_PRG_XLATE: begin
        case (a[15:13])
          WIN_BANK0_A, WIN_BANK0_B: off = {1'b0, m_prg_bank[0], 14'h0};
          WIN_BANK1: off = {2'b0, m_prg_bank[1], 13'h0};
          WIN_FIXED: off = m_prg_len - 20'h02000;
          default:   off = '0;
        endcase
        msk = a[14] ? 20'h01FFF : 20'h03FFF;
        prg_full = (({4'h0, a} & msk) | off) & (m_prg_len - 20'd1);
        r.rom_address = prg_full[18:0];
      end
      default: begin
        chr_full = ({1'b0, m_char_banks[a[12:10]], 10'h0} | {9'h0, a[9:0]})
                   & (m_chr_len - 19'd1);
        r.rom_address = chr_full;
      end
    endcase
    r.irq_line = m_irq_pend;
    r.mirror_mode = m_mirror;
    r.ram_enabled = m_ram_en;
  endtask

  // register address as seen on the bus, undoing the line swap
  function automatic logic [15:0] reg_addr(input logic [15:0] base, input logic [1:0] sub);
    logic [15:0] low;
    low = m_swap ? {14'h0, sub[0], sub[1]} : {14'h0, sub};
    return base | (16'($urandom) & 16'h0FFC) | low;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t    w;
    int unsigned pick;
    logic [1:0]  sub;
    w.mode = MODE_TICK;
    w.bus_address = 16'($urandom);
    w.write_data = 8'($urandom);
    sub = 2'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick >= 35 && pick < 60) begin
      w.mode = MODE_WRITE;
      case ($urandom_range(6))
        0: w.bus_address = reg_addr(REG_PRG_LO, sub);
        1: w.bus_address = reg_addr(REG_PRG_HI, sub);
        2: w.bus_address = reg_addr(REG_CHR_LO, sub);
        3: w.bus_address = reg_addr(REG_CHR_HI, sub);
        4: w.bus_address = reg_addr(REG_MIRROR, $urandom_range(1) ? SUB_MIRROR : sub);
        5: w.bus_address = reg_addr(REG_IRQ, sub);
        default: w.bus_address = reg_addr(REG_IRQ, SUB_IRQ_ACK);
      endcase
    end else if (pick >= 60 && pick < 78) begin
      w.mode = MODE_PRG_XLATE;
    end else if (pick >= 78 && pick < 96) begin
      w.mode = MODE_CHR_XLATE;
    end else if (pick >= 96) begin
      w.mode = MODE_WRITE;
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    out_word_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    mapper_step(w, pred);
    expected_words.push_back(typed ? typed_res : pred);
    mode_count[w.mode]++;
    items_sent++;
  endtask

  task automatic irq_run(input int unsigned max_ticks);
    in_word_t    w;
    int unsigned n_ticks;
    int unsigned pick;
    w.mode = MODE_WRITE;
    w.bus_address = reg_addr(REG_IRQ, SUB_IRQ_RELOAD);
    w.write_data = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(255, 240));
    send_word(w, 1'b0, NO_RES);
    w.bus_address = reg_addr(REG_IRQ, SUB_IRQ_CTRL);
    w.write_data = 8'($urandom);
    w.write_data[1] = ($urandom_range(9) != 0);
    send_word(w, 1'b0, NO_RES);
    n_ticks = $urandom_range(260, 10);
    if (n_ticks > max_ticks) n_ticks = max_ticks;
    repeat (n_ticks) begin
      pick = $urandom_range(99);
      w.bus_address = 16'($urandom);
      w.write_data = 8'($urandom);
      w.mode = MODE_TICK;
      if (pick < 3) begin
        w.mode = MODE_WRITE;
        w.bus_address = reg_addr(REG_IRQ, SUB_IRQ_ACK);
      end else if (pick < 10) begin
        w = rand_word();
      end
      send_word(w, 1'b0, NO_RES);
    end
  endtask

  task automatic set_config(input cfg_set_t c);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_PRG_ROM_BYTES;
    cfg_data <= c.prg;
    m_prg_len = c.prg;
    @(posedge clk);
    cfg_index <= CFG_CHR_ROM_BYTES;
    cfg_data <= {1'b0, c.chr};
    m_chr_len = c.chr;
    @(posedge clk);
    cfg_index <= CFG_SWAP_LINES;
    cfg_data <= {19'h0, c.swap};
    m_swap = c.swap;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic add_row(input logic [1:0] mode, input logic [15:0] addr,
                         input logic [7:0] data, input bit typed, input out_word_t res);
    dir_row_t row;
    row.w = {mode, addr, data};
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endtask

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (out_word.irq_line) irq_words++;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %h", out_word);
        err_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_word.rom_address !== want.rom_address) begin
          $error("rom_address: expected %h, actual %h", want.rom_address, out_word.rom_address);
          err_count++;
        end
        if (out_word.irq_line !== want.irq_line) begin
          $error("irq_line: expected %b, actual %b", want.irq_line, out_word.irq_line);
          err_count++;
        end
        if (out_word.mirror_mode !== want.mirror_mode) begin
          $error("mirror_mode: expected %0d, actual %0d", want.mirror_mode, out_word.mirror_mode);
          err_count++;
        end
        if (out_word.ram_enabled !== want.ram_enabled) begin
          $error("ram_enabled: expected %b, actual %b", want.ram_enabled, out_word.ram_enabled);
          err_count++;
        end
      end
    end
  end

  initial begin
    int seg_end;
    m_prg_len = PRG_SIZE_RESET;
    m_chr_len = CHR_SIZE_RESET;
    m_swap = 1'b0;
    foreach (m_prg_bank[i]) m_prg_bank[i] = '0;
    foreach (m_char_banks[i]) m_char_banks[i] = '0;
    m_mirror = '0;
    m_ram_en = 1'b0;
    m_irq_cnt = '0;
    m_irq_reload = '0;
    m_irq_en = 1'b0;
    m_irq_rearm = 1'b0;
    m_scan = 1'b0;
    m_irq_pend = 1'b0;
    m_presc = PRESCALE_RELOAD;
    foreach (mode_count[i]) mode_count[i] = 0;

    cfg_sets[0] = {20'd16384, 19'd1024, 1'b1};
    cfg_sets[1] = {20'd524288, 19'd262144, 1'b0};
    cfg_sets[2] = {20'd131072, 19'd16384, 1'b1};
    cfg_sets[3] = {20'd32768, 19'd262144, 1'b1};
    cfg_sets[4] = {20'd524288, 19'd1024, 1'b0};
    cfg_sets[5] = {20'd16384, 19'd131072, 1'b0};

    add_row(MODE_TICK,      16'h0000, 8'h00, 1, {19'h00000, 1'b0, 2'd0, 1'b0});
    add_row(MODE_PRG_XLATE, 16'h0000, 8'hFF, 1, {19'h00000, 1'b0, 2'd0, 1'b0});
    add_row(MODE_PRG_XLATE, 16'hFFFF, 8'h00, 1, {19'h3FFFF, 1'b0, 2'd0, 1'b0});
    add_row(MODE_CHR_XLATE, 16'hFFFF, 8'h00, 1, {19'h003FF, 1'b0, 2'd0, 1'b0});
    add_row(MODE_WRITE,     16'hB003, 8'h8C, 1, {19'h00000, 1'b0, 2'd3, 1'b1});
    add_row(MODE_WRITE,     16'h8000, 8'hFF, 0, NO_RES);
    add_row(MODE_PRG_XLATE, 16'h8000, 8'h00, 0, NO_RES);
    add_row(MODE_WRITE,     16'hC001, 8'h0A, 0, NO_RES);
    add_row(MODE_PRG_XLATE, 16'hDFFF, 8'h00, 0, NO_RES);
    add_row(MODE_WRITE,     16'hD002, 8'hFF, 0, NO_RES);
    add_row(MODE_WRITE,     16'hE003, 8'h80, 0, NO_RES);
    add_row(MODE_CHR_XLATE, 16'h0BFF, 8'h00, 0, NO_RES);
    add_row(MODE_CHR_XLATE, 16'h3C00, 8'h00, 0, NO_RES);
    add_row(MODE_WRITE,     16'h7000, 8'hFF, 0, NO_RES);
    add_row(MODE_PRG_XLATE, 16'h4000, 8'h00, 0, NO_RES);
    add_row(MODE_WRITE,     16'hF000, 8'hFE, 0, NO_RES);
    add_row(MODE_WRITE,     16'hF001, 8'h07, 0, NO_RES);
    add_row(MODE_TICK,      16'h0000, 8'h00, 0, NO_RES);
    add_row(MODE_TICK,      16'hFFFF, 8'hFF, 0, NO_RES);
    add_row(MODE_WRITE,     16'hF002, 8'h00, 0, NO_RES);
    add_row(MODE_WRITE,     16'hF001, 8'h02, 0, NO_RES);
    add_row(MODE_WRITE,     16'hF001, 8'h00, 0, NO_RES);
    add_row(MODE_TICK,      16'h1234, 8'h56, 0, NO_RES);
    add_row(MODE_WRITE,     16'hB003, 8'h00, 1, {19'h00000, 1'b0, 2'd0, 1'b0});
    add_row(MODE_WRITE,     16'hF002, 8'h00, 0, NO_RES);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 8;
    rx_idle_pct = 85;
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 8 : (p == 1) ? 85 : 0;
      rx_idle_pct = (p == 0) ? 85 : (p == 1) ? 8 : 0;
      for (int c = 0; c < 2; c++) begin
        set_config(cfg_sets[p * 2 + c]);
        // long output stall while input keeps coming
        if (p == 2 && c == 0) hold_req = 60;
        seg_end = items_sent + 215;
        while (items_sent < seg_end) begin
          if ($urandom_range(99) < 6 && seg_end - items_sent > 12) begin
            irq_run(seg_end - items_sent - 2);
          end else begin
            send_word(rand_word(), 1'b0, NO_RES);
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d words: %0d ticks, %0d register writes, %0d PRG and %0d CHR lookups",
             items_sent, mode_count[MODE_TICK], mode_count[MODE_WRITE],
             mode_count[MODE_PRG_XLATE], mode_count[MODE_CHR_XLATE]);
    $display("%0d result words showed a pending IRQ, over 7 ROM size and swap settings",
             irq_words);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cbm_pkg.sv
rtl/cbm_irq.sv
rtl/cartridge_bank_mapper_with_irq_core.sv
rtl/cbm_checker.sv
dv/tb_cartridge_bank_mapper_with_irq_core.sv
